[rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg: shared types for the UTF-8 byte stream decoder
// Result item layout and the per-byte decode step bundle.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CP_W   = 31;
  localparam int unsigned PEND_W = 3;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            bad_lead;
    logic            cut_short;
  } result_t;

  // Outcome of decoding one byte against the current state.
  typedef struct packed {
    logic              emit;
    result_t           res;
    logic [PEND_W-1:0] pending_next;
    logic [CP_W-1:0]   partial_next;
  } step_t;

endpackage

[rtl/u8d_step.sv]
// ----------------------------------------------------------------------------
// u8d_step: combinational decode of one text byte
// Classifies the byte, updates the pending count and partial value, and
// forms the result item when one is due.
// ----------------------------------------------------------------------------
module u8d_step
  import u8d_pkg::*;
(
  input  logic [7:0]        byte_val,
  input  logic [PEND_W-1:0] pending,
  input  logic [CP_W-1:0]   partial,
  output step_t             step
);

  logic [CP_W-1:0] shifted;

  assign shifted = {partial[CP_W-7:0], byte_val[5:0]};

  always_comb begin
    step.emit           = 1'b0;
    step.res.code_point = '0;
    step.res.bad_lead   = 1'b0;
    step.res.cut_short  = 1'b0;
    step.pending_next   = pending;
    step.partial_next   = partial;

    if (byte_val == 8'h00) begin
      // End of string: flush whatever sequence was left open.
      if (pending != '0) begin
        step.emit           = 1'b1;
        step.res.code_point = partial;
        step.res.cut_short  = 1'b1;
        step.pending_next   = '0;
        step.partial_next   = '0;
      end
    end else if (pending != '0) begin
      // Any nonzero byte counts as a continuation here.
      step.pending_next = pending - PEND_W'(1);
      if (pending == PEND_W'(1)) begin
        step.emit           = 1'b1;
        step.res.code_point = shifted;
        step.partial_next   = '0;
      end else begin
        step.partial_next = shifted;
      end
    end else begin
      unique case (byte_val) inside
        8'b0???????: begin
          step.emit           = 1'b1;
          step.res.code_point = CP_W'(byte_val);
        end
        8'b110?????: begin
          step.partial_next = CP_W'(byte_val[4:0]);
          step.pending_next = PEND_W'(1);
        end
        8'b1110????: begin
          step.partial_next = CP_W'(byte_val[3:0]);
          step.pending_next = PEND_W'(2);
        end
        8'b11110???: begin
          step.partial_next = CP_W'(byte_val[2:0]);
          step.pending_next = PEND_W'(3);
        end
        8'b111110??: begin
          step.partial_next = CP_W'(byte_val[1:0]);
          step.pending_next = PEND_W'(4);
        end
        8'b1111110?: begin
          step.partial_next = CP_W'(byte_val[0]);
          step.pending_next = PEND_W'(5);
        end
        default: begin
          // Stray continuation byte or 0xFE/0xFF: pass the raw byte on.
          step.emit           = 1'b1;
          step.res.code_point = CP_W'(byte_val);
          step.res.bad_lead   = 1'b1;
        end
      endcase
    end
  end

endmodule

[rtl/u8d_out_reg.sv]
// ----------------------------------------------------------------------------
// u8d_out_reg: result register of the decoder
// Holds one result item until the consumer takes it; reloads in the same
// cycle that the held item leaves.
// ----------------------------------------------------------------------------
module u8d_out_reg
  import u8d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    room,
  output logic    hold_valid,
  output result_t hold_res,
  input  logic    take
);

  assign room = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (room) begin
      hold_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      hold_res <= load_res;
    end
  end

endmodule

[rtl/utf8_byte_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder: byte-serial UTF-8 decoder with six-byte forms
// Turns a stream of text bytes into code points, flagging bad leads and
// strings that end in the middle of a sequence.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ----------------------------------------
//   input    byte_valid/byte_ready  byte_in[7:0]
//   output   cp_valid/cp_ready      code_point[30:0], bad_lead, cut_short
//
// One byte is taken every cycle while the result side keeps up. A byte is
// registered in the input register, then the decode step and the state
// update happen on the way into the result register, from which the result
// shows on the outputs; a full result register can hold a byte back in the
// input register. The decode step is a single pass of shallow logic: a shift
// of six bits and a lead pattern match.
// Synchronous reset empties both registers and returns the decoder to idle.
// When the result register is full and not being taken, the input register
// holds its byte and byte_ready falls only if that register is also full.
//
module utf8_byte_stream_decoder
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  logic [7:0]      byte_in,
  output logic            cp_valid,
  input  logic            cp_ready,
  output logic [CP_W-1:0] code_point,
  output logic            bad_lead,
  output logic            cut_short
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Decoder state: continuation bytes still expected and the value so far.
  logic [PEND_W-1:0] pending;
  logic [CP_W-1:0]   partial;

  step_t   step;
  result_t out_res;
  logic    out_room;
  logic    fire;

  // The held byte is decoded whenever the result register can take what it
  // produces; a byte that yields no result still has to wait its turn so the
  // state update stays in order.
  assign fire       = in_valid && out_room;
  assign byte_ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_ready) begin
      in_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      in_byte <= byte_in;
    end
  end

  u8d_step u_step (
    .byte_val (in_byte),
    .pending  (pending),
    .partial  (partial),
    .step     (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      partial <= '0;
    end else if (fire) begin
      pending <= step.pending_next;
      partial <= step.partial_next;
    end
  end

  u8d_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire && step.emit),
    .load_res   (step.res),
    .room       (out_room),
    .hold_valid (cp_valid),
    .hold_res   (out_res),
    .take       (cp_ready)
  );

  assign code_point = out_res.code_point;
  assign bad_lead   = out_res.bad_lead;
  assign cut_short  = out_res.cut_short;

`ifndef SYNTHESIS
  // Between sequences the partial value is always cleared.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (pending == '0) |-> (partial == '0))
    else $error("partial value not cleared while idle");

  // A result is never both a raw bad lead and a cut-short flush.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    cp_valid |-> !(bad_lead && cut_short))
    else $error("bad_lead and cut_short both set");

  // A raw byte passed through is always in 0x80..0xFF.
  a_bad_range: assert property (@(posedge clk) disable iff (rst)
    (cp_valid && bad_lead) |-> (code_point[CP_W-1:8] == '0 && code_point[7]))
    else $error("bad lead value out of range");

  // A sequence cut short is missing at least one continuation: 25 bits max.
  a_cut_width: assert property (@(posedge clk) disable iff (rst)
    (cp_valid && cut_short) |-> (code_point[CP_W-1:25] == '0))
    else $error("cut-short value too wide");
`endif

endmodule
